// File: rtl/core/tmtt_pkg.sv
package tmtt_pkg;

    localparam int FifoDepth = 4;
    localparam int PtrW      = $clog2(FifoDepth);

    typedef struct packed {
        logic [7:0] char_in;
        logic       doc_end;
    } in_word_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [1:0] token_kind;
        logic [7:0] data_byte;
        logic       step_last;
    } out_word_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_LT     = 3'd1,
        MODE_STAG   = 3'd2,
        MODE_ETAG   = 3'd3,
        MODE_TEXT   = 3'd4,
        MODE_ENT    = 3'd5,
        MODE_IGNORE = 3'd6
    } mode_t;

    localparam logic [1:0] EV_BYTE    = 2'd0;
    localparam logic [1:0] EV_END     = 2'd1;
    localparam logic [1:0] EV_UNKNOWN = 2'd2;
    localparam logic [1:0] EV_OPEN    = 2'd3;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_ENDT  = 2'd1;
    localparam logic [1:0] KIND_TEXT  = 2'd2;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_L     = 8'h6C;

    localparam logic [2:0] ENT_MAX  = 3'd4;
    localparam logic [2:0] ENT_LONG = 3'd5;

endpackage

// File: rtl/core/markup_tag_text_tokenizer.sv
// Markup tokenizer: one character in, zero to two token events out.
// Input channel s_valid/s_ready/s_data carries a word of {char_in, doc_end}.
// Output channel m_valid/m_ready/m_data carries {event_res, token_kind,
// data_byte, step_last}; step_last marks the final event caused by a word.
// Each accepted word is parsed in the cycle it is accepted and its events
// are written into a four-entry output queue; m_data shows the oldest
// queued event. One word per cycle is taken while the queue holds at most
// two events, so words that cause one event or none stream at one per
// cycle; a word causing two events puts two events in the queue, and the
// queue depth sets how far that can run ahead.
// If the receiver stalls, the queue fills and s_ready drops until space
// for two more events is free; nothing is lost or reordered.
// A word with doc_end set flushes the open token and returns the parser to
// idle. Reset (aresetn low, synchronous) empties the queue and puts the
// parser in idle.
module markup_tag_text_tokenizer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tmtt_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tmtt_pkg::out_word_t m_data
);
    import tmtt_pkg::*;

    mode_t          mode_reg, mode_next;
    logic [2:0]     ecount_reg, ecount_next;
    logic [7:0]     echars_reg [4];
    logic           ewr_en;

    out_word_t      fifo_reg [FifoDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]  count_reg, count_next;

    logic           s_fire, m_fire;
    logic [7:0]     c;

    logic           main_vld, flush_vld;
    out_word_t      main_res, flush_res;
    out_word_t      slot0, slot1;
    logic [1:0]     n_res;
    logic           ent_hit;
    logic [7:0]     ent_byte;

    assign c       = s_data.char_in;
    assign s_ready = (count_reg <= (PtrW+1)'(FifoDepth - 2));
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (count_reg != '0);
    assign m_fire  = m_valid && m_ready;
    assign m_data  = fifo_reg[rd_ptr_reg];

    // entity lookup on the stored name
    always_comb begin
        ent_hit  = 1'b0;
        ent_byte = 8'h00;
        if (ecount_reg == 3'd4 && echars_reg[0] == CH_Q && echars_reg[1] == CH_U &&
            echars_reg[2] == CH_O && echars_reg[3] == CH_T) begin
            ent_hit  = 1'b1;
            ent_byte = CH_QUOTE;
        end else if (ecount_reg == 3'd2 && echars_reg[1] == CH_T) begin
            if (echars_reg[0] == CH_G) begin
                ent_hit  = 1'b1;
                ent_byte = CH_GT;
            end else if (echars_reg[0] == CH_L) begin
                ent_hit  = 1'b1;
                ent_byte = CH_LT;
            end
        end
    end

    always_comb begin
        mode_t tag_mode;
        logic [1:0] tag_kind;
        tag_mode    = mode_reg;
        tag_kind    = KIND_START;
        mode_next   = mode_reg;
        ecount_next = ecount_reg;
        ewr_en      = 1'b0;
        main_vld    = 1'b0;
        main_res    = '{event_res: EV_BYTE, token_kind: KIND_TEXT, data_byte: c,
                        step_last: 1'b0};
        flush_vld   = 1'b0;
        flush_res   = '{event_res: EV_END, token_kind: KIND_TEXT, data_byte: 8'h00,
                        step_last: 1'b0};

        unique case (mode_reg)
            MODE_LT, MODE_STAG, MODE_ETAG: begin
                if (mode_reg == MODE_LT && c == CH_SLASH) begin
                    mode_next = MODE_ETAG;
                end else begin
                    tag_mode = (mode_reg == MODE_ETAG) ? MODE_ETAG : MODE_STAG;
                    tag_kind = (mode_reg == MODE_ETAG) ? KIND_ENDT : KIND_START;
                    main_vld = 1'b1;
                    main_res.token_kind = tag_kind;
                    if (c == CH_GT) begin
                        main_res.event_res = EV_END;
                        main_res.data_byte = 8'h00;
                        mode_next = MODE_IDLE;
                    end else begin
                        mode_next = tag_mode;
                    end
                end
            end
            MODE_TEXT: begin
                if (c == CH_LT) begin
                    main_vld = 1'b1;
                    main_res.event_res = EV_END;
                    main_res.data_byte = 8'h00;
                    mode_next = MODE_LT;
                end else if (c == CH_AMP) begin
                    mode_next   = MODE_ENT;
                    ecount_next = '0;
                end else begin
                    main_vld = 1'b1;
                end
            end
            MODE_ENT: begin
                if (c == CH_SEMI) begin
                    main_vld = 1'b1;
                    if (ent_hit) begin
                        main_res.data_byte = ent_byte;
                        mode_next = MODE_TEXT;
                    end else begin
                        main_res.event_res = EV_UNKNOWN;
                        main_res.data_byte = 8'h00;
                        mode_next = MODE_IGNORE;
                    end
                end else if (ecount_reg < ENT_MAX) begin
                    ewr_en      = 1'b1;
                    ecount_next = ecount_reg + 3'd1;
                end else begin
                    ecount_next = ENT_LONG;
                end
            end
            MODE_IGNORE: begin
            end
            default: begin
                if (c == CH_LT) begin
                    mode_next = MODE_LT;
                end else if (c == CH_AMP) begin
                    mode_next   = MODE_ENT;
                    ecount_next = '0;
                end else begin
                    mode_next = MODE_TEXT;
                    main_vld  = 1'b1;
                end
            end
        endcase

        if (s_data.doc_end) begin
            unique case (mode_next)
                MODE_LT, MODE_STAG: begin
                    flush_vld = 1'b1;
                    flush_res.token_kind = KIND_START;
                end
                MODE_ETAG: begin
                    flush_vld = 1'b1;
                    flush_res.token_kind = KIND_ENDT;
                end
                MODE_TEXT: begin
                    flush_vld = 1'b1;
                end
                MODE_ENT: begin
                    flush_vld = 1'b1;
                    flush_res.event_res = EV_OPEN;
                end
                default: begin
                end
            endcase
            mode_next   = MODE_IDLE;
            ecount_next = '0;
        end
    end

    // pack up to two events, last flag on the final one
    always_comb begin
        slot0 = main_vld ? main_res : flush_res;
        slot1 = flush_res;
        n_res = 2'(main_vld) + 2'(flush_vld);
        slot0.step_last = (n_res == 2'd1);
        slot1.step_last = 1'b1;
    end

    always_comb begin
        count_next = count_reg;
        if (s_fire) begin
            count_next = count_next + (PtrW+1)'(n_res);
        end
        if (m_fire) begin
            count_next = count_next - (PtrW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            ecount_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (s_fire) begin
                mode_reg   <= mode_next;
                ecount_reg <= ecount_next;
                wr_ptr_reg <= wr_ptr_reg + PtrW'(n_res);
            end
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && ewr_en) begin
            echars_reg[ecount_reg[1:0]] <= c;
        end
        if (s_fire && n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= slot0;
        end
        if (s_fire && n_res == 2'd2) begin
            fifo_reg[wr_ptr_reg + PtrW'(1)] <= slot1;
        end
    end

endmodule

// File: test/tb_markup_tag_text_tokenizer.sv
module tb_markup_tag_text_tokenizer;
    import tmtt_pkg::*;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    markup_tag_text_tokenizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // pending input words; a set flag makes the sender wait until all expected events are out
    in_word_t  chars_q[$];
    bit        drain_q[$];
    out_word_t events_due[$];

    int n_sent     = 0;
    int errors     = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;
    bit quiet;

    assign quiet = (n_sent >= 700) && (n_sent < 950);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------- tokenizer state (predictor) ----------------
    mode_t      pmode;
    logic       txt_open;
    logic [7:0] ent_name [4];
    logic [2:0] ent_len;
    out_word_t  step_ev [2];
    int         step_n;

    function automatic void reset_parser();
        pmode    = MODE_IDLE;
        txt_open = 1'b0;
        for (int i = 0; i < 4; i++) ent_name[i] = 8'h00;
        ent_len  = 3'd0;
    endfunction

    function automatic void emit(logic [1:0] ev, logic [1:0] kind, logic [7:0] b);
        if (step_n < 2) begin
            step_ev[step_n].event_res  = ev;
            step_ev[step_n].token_kind = kind;
            step_ev[step_n].data_byte  = b;
            step_ev[step_n].step_last  = 1'b0;
            step_n++;
        end
    endfunction

    function automatic void tag_byte(logic [7:0] c, logic [1:0] kind);
        if (c == CH_GT) begin
            emit(EV_END, kind, 8'h00);
            pmode = MODE_IDLE;
        end else begin
            emit(EV_BYTE, kind, c);
        end
    endfunction

    // bit 8 set when the entity name is known
    function automatic logic [8:0] entity_value();
        if (ent_len == ENT_MAX && ent_name[0] == CH_Q && ent_name[1] == CH_U &&
            ent_name[2] == CH_O && ent_name[3] == CH_T)
            return {1'b1, CH_QUOTE};
        if (ent_len == 3'd2 && ent_name[1] == CH_T) begin
            if (ent_name[0] == CH_G) return {1'b1, CH_GT};
            if (ent_name[0] == CH_L) return {1'b1, CH_LT};
        end
        return 9'd0;
    endfunction

    function automatic void tokenize_char(in_word_t w);
        logic [7:0] c;
        logic [8:0] dv;
        c = w.char_in;
        step_n = 0;
        case (pmode)
            MODE_LT: begin
                if (c == CH_SLASH) begin
                    pmode = MODE_ETAG;
                end else begin
                    pmode = MODE_STAG;
                    tag_byte(c, KIND_START);
                end
            end
            MODE_STAG: tag_byte(c, KIND_START);
            MODE_ETAG: tag_byte(c, KIND_ENDT);
            MODE_TEXT: begin
                if (c == CH_LT) begin
                    emit(EV_END, KIND_TEXT, 8'h00);
                    txt_open = 1'b0;
                    pmode    = MODE_LT;
                end else if (c == CH_AMP) begin
                    pmode   = MODE_ENT;
                    ent_len = 3'd0;
                end else begin
                    emit(EV_BYTE, KIND_TEXT, c);
                end
            end
            MODE_ENT: begin
                if (c == CH_SEMI) begin
                    dv = entity_value();
                    if (!dv[8]) begin
                        emit(EV_UNKNOWN, KIND_TEXT, 8'h00);
                        txt_open = 1'b0;
                        pmode    = MODE_IGNORE;
                    end else begin
                        emit(EV_BYTE, KIND_TEXT, dv[7:0]);
                        txt_open = 1'b1;
                        pmode    = MODE_TEXT;
                    end
                end else if (ent_len < ENT_MAX) begin
                    ent_name[ent_len[1:0]] = c;
                    ent_len++;
                end else begin
                    ent_len = ENT_LONG;
                end
            end
            MODE_IGNORE: ;
            default: begin
                if (c == CH_LT) begin
                    pmode = MODE_LT;
                end else if (c == CH_AMP) begin
                    pmode   = MODE_ENT;
                    ent_len = 3'd0;
                end else begin
                    pmode    = MODE_TEXT;
                    txt_open = 1'b1;
                    emit(EV_BYTE, KIND_TEXT, c);
                end
            end
        endcase
        if (w.doc_end) begin
            case (pmode)
                MODE_LT, MODE_STAG: emit(EV_END, KIND_START, 8'h00);
                MODE_ETAG:          emit(EV_END, KIND_ENDT, 8'h00);
                MODE_TEXT:          emit(EV_END, KIND_TEXT, 8'h00);
                MODE_ENT:           emit(EV_OPEN, KIND_TEXT, 8'h00);
                default: ;
            endcase
            reset_parser();
        end
        if (step_n > 0) step_ev[step_n-1].step_last = 1'b1;
        for (int i = 0; i < step_n; i++) events_due.insert(events_due.size(), step_ev[i]);
    endfunction

    // ---------------- stimulus builders ----------------
    task automatic push_char(logic [7:0] c, bit end_doc);
        in_word_t w;
        w.char_in = c;
        w.doc_end = end_doc;
        chars_q.insert(chars_q.size(), w);
        drain_q.insert(drain_q.size(), 1'b0);
    endtask

    task automatic push_str(string s, bit end_doc);
        for (int i = 0; i < s.len(); i++) push_char(s[i], end_doc && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] tag_name_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_GT);
        return c;
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_LT || c == CH_AMP);
        return c;
    endfunction

    task automatic push_random_doc();
        logic [7:0] doc[$];
        string      known [3];
        string      letters;
        string      e;
        int         k;
        int         n;
        known[0] = "&quot;";
        known[1] = "&gt;";
        known[2] = "&lt;";
        letters  = "quotgl";
        repeat ($urandom_range(1, 6)) begin
            k = $urandom_range(0, 11);
            if (k <= 4) begin
                doc.insert(doc.size(), CH_LT);
                if (k >= 3) doc.insert(doc.size(), CH_SLASH);
                n = $urandom_range(0, 4);
                repeat (n) doc.insert(doc.size(), tag_name_char());
                doc.insert(doc.size(), CH_GT);
            end else if (k <= 9) begin
                n = $urandom_range(1, 5);
                repeat (n) doc.insert(doc.size(), text_char());
                if ($urandom_range(0, 2) == 0) begin
                    e = known[$urandom_range(0, 2)];
                    for (int i = 0; i < e.len(); i++) doc.insert(doc.size(), e[i]);
                end
            end else begin
                // entity that is mostly unknown or too long
                doc.insert(doc.size(), CH_AMP);
                n = $urandom_range(0, 6);
                repeat (n) doc.insert(doc.size(), letters[$urandom_range(0, 5)]);
                doc.insert(doc.size(), CH_SEMI);
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, doc.size());
            doc = doc[0:n-1];
        end
        if ($urandom_range(0, 7) == 0) begin
            doc.insert(doc.size(), CH_AMP);
            n = $urandom_range(0, 3);
            repeat (n) doc.insert(doc.size(), letters[$urandom_range(0, 5)]);
        end
        for (int i = 0; i < doc.size(); i++) push_char(doc[i], i == doc.size() - 1);
    endtask

    task automatic push_noise();
        int n;
        n = $urandom_range(5, 30);
        for (int i = 0; i < n; i++)
            push_char(8'($urandom_range(0, 255)),
                      (i == n - 1) || ($urandom_range(0, 15) == 0));
    endtask

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            reset_parser();
        end else begin
            if (s_valid && s_ready) begin
                tokenize_char(s_data);
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (chars_q.size() != 0 && !(drain_q[0] && events_due.size() != 0) &&
                    (quiet || $urandom_range(0, 99) >= 16)) begin
                    s_valid <= 1'b1;
                    s_data  <= chars_q.pop_front();
                    void'(drain_q.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (events_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected event: ev=%0d kind=%0d byte=%02h last=%0d",
                                 m_data.event_res, m_data.token_kind, m_data.data_byte,
                                 m_data.step_last);
                end else begin
                    automatic out_word_t exp_ev = events_due.pop_front();
                    if (m_data.event_res !== exp_ev.event_res ||
                        m_data.token_kind !== exp_ev.token_kind ||
                        m_data.data_byte !== exp_ev.data_byte ||
                        m_data.step_last !== exp_ev.step_last) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp ev=%0d kind=%0d byte=%02h last=%0d,",
                                      " got ev=%0d kind=%0d byte=%02h last=%0d"},
                                     exp_ev.event_res, exp_ev.token_kind, exp_ev.data_byte,
                                     exp_ev.step_last, m_data.event_res, m_data.token_kind,
                                     m_data.data_byte, m_data.step_last);
                    end
                end
            end
            // one long hold-off so the output queue fills and input backs up
            if (!stall_done && n_sent >= 300) begin
                stall_done = 1'b1;
                stall_left = 250;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // ---------------- test sequence ----------------
    initial begin
        // lone '<', bare "</", '<' and '&' inside an unterminated tag
        push_str("<", 1'b1);
        push_str("</", 1'b1);
        push_str("<&<", 1'b1);
        // end tag with top byte, text with decoded entity, unknown entity then ignored input
        push_str("</", 1'b0);
        push_char(8'hFF, 1'b0);
        push_str(">x&gt;&q;", 1'b0);
        push_str("z", 1'b1);
        // entity open at end of document
        push_str("&l", 1'b1);
        push_str("&quot;", 1'b0);
        push_char(8'h00, 1'b1);

        while (chars_q.size() < 1200) begin
            if ($urandom_range(0, 9) == 0) push_noise();
            else push_random_doc();
        end
        drain_q[500] = 1'b1;
        drain_q[1100] = 1'b1;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (chars_q.size() != 0 || s_valid) @(posedge aclk);
        while (events_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (errors == 0 && events_due.size() == 0)
            $display("tb_markup_tag_text_tokenizer OK");
        else
            $display("tb_markup_tag_text_tokenizer NOT OK");
        $finish;
    end

    initial begin
        #400000;
        $display("tb_markup_tag_text_tokenizer NOT OK");
        $finish;
    end

endmodule

// File: files.f
rtl/core/tmtt_pkg.sv
rtl/core/markup_tag_text_tokenizer.sv
test/tb_markup_tag_text_tokenizer.sv
